@@ src/hrrm_pkg.sv @@
// shared types and constants of the hid report rate meter
// no dependencies

package hrrm_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int MAX_LINES = 16;
	localparam int MIN_VOTES = 8;
	localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
	localparam logic [63:0] QUARTER_SEC_NS = 64'd250000000;
	localparam logic [31:0] GAP_RESET = 32'd50000000;

	localparam logic [1:0] CMD_EVENT = 2'd0;
	localparam logic [1:0] CMD_STOP = 2'd1;
	localparam logic [1:0] CMD_SUMMARY = 2'd2;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_WINDOW = 2'd1;
	localparam logic [1:0] REG_GAP = 2'd2;

	localparam logic [1:0] ROLE_UNKNOWN = 2'd0;
	localparam logic [1:0] ROLE_MOUSE = 2'd1;
	localparam logic [1:0] ROLE_KEYBOARD = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_ALLOC,
		ST_UPDATE,
		ST_TIME,
		ST_STOPSCAN,
		ST_STOPCHK,
		ST_FLUSH,
		ST_FLUSHOUT,
		ST_SUMMARY,
		ST_SUMOUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture input item
		logic clr_idx;     // slot index to zero
		logic inc_idx;     // next slot
		logic match_chk;   // compare key of current slot
		logic alloc;       // take new slot
		logic err_upd;     // count error
		logic good_upd;    // length vote, interval, counts
		logic time_upd;    // window start and flush check
		logic max_upd;     // fold last time into stop max
		logic stop_chk;    // evaluate stop condition
		logic line_ld;     // load output line from current slot
		logic sum_sel;     // line from totals
		logic win_clr;     // clear window stats of current slot
		logic set_start;   // window start to flush time
		logic out_last;    // mark line as last
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic idx_end;     // index reached slot count
		logic idx_last;    // last slot or last line of budget
		logic matched;
		logic full;
		logic dir_in;
		logic is_err;
		logic flush_go;
		logic stop_go;
		logic win_active;  // current slot has reports in window
		logic no_slots;
		logic more_lines;  // another line follows in flush
		logic lines_left;  // line budget not spent
		logic out_busy;
		logic [1:0] cmd;
	} status_t;

endpackage

@@ src/hid_report_rate_meter.sv @@
// hid report rate meter, top level
// valid/stall channels: in_valid/in_stall take one command item; results leave on
// out_valid/out_stall, one slot line per result, last_item marks the end of a burst
// one item is handled at a time; in_stall stays high until it is done
// a good transfer to a known slot goes through search, comparing the held slots in
// order, then update and time; one that takes a new slot searches all slots already
// held, then goes through alloc, update and time; a failed or ignored transfer ends sooner
// a window flush or summary then visits the slots in order, each line showing in
// the cycle after it is built; while the receiver stalls the single output
// register holds the line and the flush or summary waits
// a stop command scans all slot last times, one slot a cycle, then checks the span
// reset empties the slot table, clears window start and loads register defaults
// registers are written through cfg_we/cfg_index/cfg_data; the user writes them only while idle, not enforced here
// uses hrrm_pkg, hrrm_ctrl, hrrm_dp

module hid_report_rate_meter #(
	parameter int NUM_SLOTS = hrrm_pkg::NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] bus,
	input  logic [6:0]  device_address,
	input  logic [7:0]  endpoint,
	input  logic        dir_in,
	input  logic        status_error,
	input  logic [15:0] report_length,
	input  logic [63:0] timestamp_ns,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_bus,
	output logic [6:0]  out_device,
	output logic [7:0]  out_endpoint,
	output logic [1:0]  role,
	output logic [63:0] report_count,
	output logic [63:0] interval_count,
	output logic [63:0] interval_sum_ns,
	output logic [31:0] min_interval_ns,
	output logic [31:0] max_interval_ns,
	output logic [63:0] gap_count,
	output logic [31:0] error_count,
	output logic        last_item
);
	import hrrm_pkg::*;

	logic        enable_q;
	logic [11:0] window_q;
	logic [31:0] gap_q;
	cmd_t        cm;
	status_t     st;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			window_q <= 12'd1;
			gap_q <= GAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_WINDOW: window_q <= cfg_data[11:0];
				REG_GAP: gap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hrrm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .enable(enable_q), .in_valid(in_valid),
		.in_stall(in_stall), .st(st), .cm(cm)
	);

	hrrm_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .window_seconds(window_q), .gap_threshold_ns(gap_q),
		.cmd(cmd), .bus(bus), .device_address(device_address), .endpoint(endpoint),
		.dir_in(dir_in), .status_error(status_error), .report_length(report_length),
		.timestamp_ns(timestamp_ns), .cm(cm), .st(st), .out_valid(out_valid),
		.out_stall(out_stall), .out_bus(out_bus), .out_device(out_device),
		.out_endpoint(out_endpoint), .role(role), .report_count(report_count),
		.interval_count(interval_count), .interval_sum_ns(interval_sum_ns),
		.min_interval_ns(min_interval_ns), .max_interval_ns(max_interval_ns),
		.gap_count(gap_count), .error_count(error_count), .last_item(last_item)
	);
endmodule

@@ src/hrrm_ctrl.sv @@
// controller of the hid report rate meter
// uses hrrm_pkg

module hrrm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               enable,
	input  logic               in_valid,
	output logic               in_stall,
	input  hrrm_pkg::status_t  st,
	output hrrm_pkg::cmd_t     cm
);
	import hrrm_pkg::*;

	state_t state_q, state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_n;
	end

	// next state and commands
	always_comb begin
		state_n = state_q;
		cm = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cm.load = 1'b1;
					cm.clr_idx = 1'b1;
					if (enable) begin
						if (st.cmd == CMD_EVENT) state_n = ST_SEARCH;
						else if (st.cmd == CMD_STOP) state_n = ST_STOPSCAN;
						else if (st.cmd == CMD_SUMMARY) state_n = ST_SUMMARY;
					end
				end
			end
			ST_SEARCH: begin
				if (!st.dir_in) state_n = ST_IDLE;
				else if (st.idx_end) begin
					if (st.full) state_n = ST_IDLE;
					else state_n = ST_ALLOC;
				end else if (st.matched) state_n = ST_UPDATE;
				else cm.inc_idx = 1'b1;
			end
			ST_ALLOC: begin
				cm.alloc = 1'b1;
				state_n = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (st.is_err) begin
					cm.err_upd = 1'b1;
					state_n = ST_IDLE;
				end else begin
					cm.good_upd = 1'b1;
					state_n = ST_TIME;
				end
			end
			ST_TIME: begin
				cm.time_upd = 1'b1;
				cm.clr_idx = 1'b1;
				if (st.flush_go) state_n = ST_FLUSH;
				else state_n = ST_IDLE;
			end
			ST_STOPSCAN: begin
				if (st.idx_end) state_n = ST_STOPCHK;
				else begin
					cm.max_upd = 1'b1;
					cm.inc_idx = 1'b1;
				end
			end
			ST_STOPCHK: begin
				cm.stop_chk = 1'b1;
				cm.clr_idx = 1'b1;
				if (st.stop_go) state_n = ST_FLUSH;
				else state_n = ST_IDLE;
			end
			ST_FLUSH: begin
				if (st.idx_end) begin
					cm.set_start = 1'b1;
					state_n = ST_IDLE;
				end else if (!st.out_busy) begin
					cm.win_clr = 1'b1;
					cm.inc_idx = 1'b1;
					if (st.win_active && st.lines_left) begin
						cm.line_ld = 1'b1;
						cm.out_last = !st.more_lines;
					end
				end
			end
			ST_SUMMARY: begin
				if (st.idx_end || !st.lines_left) state_n = ST_IDLE;
				else if (!st.out_busy) begin
					cm.line_ld = 1'b1;
					cm.sum_sel = 1'b1;
					cm.out_last = st.idx_last;
					cm.inc_idx = 1'b1;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end
endmodule

@@ src/hrrm_dp.sv @@
// datapath of the hid report rate meter: slot table, statistics, output line
// uses hrrm_pkg

module hrrm_dp #(
	parameter int NUM_SLOTS = hrrm_pkg::NUM_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [11:0]        window_seconds,
	input  logic [31:0]        gap_threshold_ns,
	input  logic [1:0]         cmd,
	input  logic [15:0]        bus,
	input  logic [6:0]         device_address,
	input  logic [7:0]         endpoint,
	input  logic               dir_in,
	input  logic               status_error,
	input  logic [15:0]        report_length,
	input  logic [63:0]        timestamp_ns,
	input  hrrm_pkg::cmd_t     cm,
	output hrrm_pkg::status_t  st,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        out_bus,
	output logic [6:0]         out_device,
	output logic [7:0]         out_endpoint,
	output logic [1:0]         role,
	output logic [63:0]        report_count,
	output logic [63:0]        interval_count,
	output logic [63:0]        interval_sum_ns,
	output logic [31:0]        min_interval_ns,
	output logic [31:0]        max_interval_ns,
	output logic [63:0]        gap_count,
	output logic [31:0]        error_count,
	output logic               last_item
);
	import hrrm_pkg::*;

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int LW = $clog2(MAX_LINES + 1);

	// captured item
	logic [15:0] bus_q, len_q;
	logic [6:0]  dev_q;
	logic [7:0]  ep_q;
	logic        dir_q, err_q;
	logic [63:0] ts_q;

	// slot table
	logic [15:0] k_bus_q [NUM_SLOTS];
	logic [6:0]  k_dev_q [NUM_SLOTS];
	logic [7:0]  k_ep_q  [NUM_SLOTS];
	logic [1:0]  role_q  [NUM_SLOTS];
	logic [63:0] last_q  [NUM_SLOTS];
	logic [31:0] err_cnt_q [NUM_SLOTS];
	logic [31:0] vote_q  [NUM_SLOTS][3];
	logic [63:0] w_cnt_q [NUM_SLOTS], w_iv_q [NUM_SLOTS], w_sum_q [NUM_SLOTS];
	logic [63:0] w_gap_q [NUM_SLOTS];
	logic [31:0] w_min_q [NUM_SLOTS], w_max_q [NUM_SLOTS];
	logic [63:0] t_cnt_q [NUM_SLOTS], t_iv_q [NUM_SLOTS], t_sum_q [NUM_SLOTS];
	logic [63:0] t_gap_q [NUM_SLOTS];
	logic [31:0] t_min_q [NUM_SLOTS], t_max_q [NUM_SLOTS];

	logic [CW-1:0] slot_count_q, idx_q;
	logic [63:0]   window_start_q, now_q, win_ns_q;
	logic [LW-1:0] lines_q;
	logic          flush_go_q;
	logic [IW-1:0] ix;

	assign ix = idx_q[IW-1:0];

	// interval of the current item against the slot's last time
	logic        iv_ok, iv_gap;
	logic [63:0] iv;
	logic [31:0] iv32;
	assign iv_ok = (last_q[ix] != 64'd0) && (ts_q > last_q[ix]);
	assign iv = ts_q - last_q[ix];
	assign iv_gap = iv > {32'd0, gap_threshold_ns};
	assign iv32 = iv[31:0];

	// stop goes ahead when the latest report is a quarter window past the start
	logic [63:0] quarter_ns;
	logic        stop_ok;
	assign quarter_ns = {52'd0, window_seconds} * QUARTER_SEC_NS;
	assign stop_ok = (window_start_q != 0) && (now_q > window_start_q) &&
		(now_q - window_start_q >= quarter_ns);

	// vote class and tallies after this report
	logic [31:0] v0, v1, v2;
	logic [33:0] vtot;
	logic        c_mouse, c_kbd;
	assign c_mouse = len_q == 16'd4;
	assign c_kbd = (len_q == 16'd8) || (len_q == 16'd9) || (len_q == 16'd17);
	always_comb begin
		v0 = vote_q[ix][0];
		v1 = vote_q[ix][1];
		v2 = vote_q[ix][2];
		if (c_mouse) v0 = (v0 == '1) ? v0 : v0 + 32'd1;
		else if (c_kbd) v1 = (v1 == '1) ? v1 : v1 + 32'd1;
		else v2 = (v2 == '1) ? v2 : v2 + 32'd1;
		vtot = {2'b0, v0} + {2'b0, v1} + {2'b0, v2};
	end

	// active slot scan helpers
	logic [CW-1:0] idx_nx;
	logic          more_act;
	assign idx_nx = idx_q + CW'(1);
	always_comb begin
		more_act = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (CW'(i) > idx_q && CW'(i) < slot_count_q && w_cnt_q[i] != 64'd0)
				more_act = 1'b1;
	end

	always_comb begin
		st = '0;
		st.idx_end = idx_q >= slot_count_q;
		st.idx_last = (idx_nx >= slot_count_q) || (lines_q >= LW'(MAX_LINES - 1));
		st.matched = (k_bus_q[ix] == bus_q) && (k_dev_q[ix] == dev_q) && (k_ep_q[ix] == ep_q);
		st.full = slot_count_q >= CW'(NUM_SLOTS);
		st.dir_in = dir_q;
		st.is_err = err_q;
		st.flush_go = flush_go_q;
		st.stop_go = stop_ok;
		st.win_active = w_cnt_q[ix] != 64'd0;
		st.no_slots = slot_count_q == '0;
		st.more_lines = more_act && (lines_q < LW'(MAX_LINES - 1));
		st.lines_left = lines_q < LW'(MAX_LINES);
		st.out_busy = out_valid && out_stall;
		st.cmd = cmd;
	end

	// slot index, line count, slot count, window start and flush flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= '0;
			window_start_q <= '0;
			idx_q <= '0;
			lines_q <= '0;
			flush_go_q <= 1'b0;
		end else begin
			if (cm.clr_idx) idx_q <= '0;
			else if (cm.inc_idx) idx_q <= idx_nx;
			if (cm.load) lines_q <= '0;
			else if (cm.line_ld) lines_q <= lines_q + LW'(1);
			if (cm.alloc) slot_count_q <= slot_count_q + CW'(1);
			if (cm.time_upd) begin
				flush_go_q <= 1'b0;
				if (window_start_q == 64'd0) window_start_q <= ts_q;
			end
			if (cm.good_upd) begin
				// decided on window start as it will stand after this report
				flush_go_q <= ((window_start_q != 0) ? (ts_q > window_start_q &&
					ts_q - window_start_q >= win_ns_q) : 1'b0);
			end
			if (cm.set_start) window_start_q <= now_q;
		end
	end

	// window length, item capture, stop span and flush time
	always_ff @(posedge clk) begin
		win_ns_q <= {52'd0, window_seconds} * NS_PER_SEC;
		if (cm.load) begin
			bus_q <= bus; dev_q <= device_address; ep_q <= endpoint;
			dir_q <= dir_in; err_q <= status_error; len_q <= report_length;
			ts_q <= timestamp_ns;
			now_q <= 64'd0;
		end
		if (cm.good_upd) now_q <= ts_q;
		if (cm.max_upd && last_q[ix] > now_q) now_q <= last_q[ix];
	end

	// slot table updates
	always_ff @(posedge clk) begin
		if (cm.alloc) begin
			k_bus_q[ix] <= bus_q; k_dev_q[ix] <= dev_q; k_ep_q[ix] <= ep_q;
			role_q[ix] <= ROLE_UNKNOWN; last_q[ix] <= '0; err_cnt_q[ix] <= '0;
			for (int j = 0; j < 3; j++) vote_q[ix][j] <= '0;
			w_cnt_q[ix] <= '0; w_iv_q[ix] <= '0; w_sum_q[ix] <= '0; w_gap_q[ix] <= '0;
			w_min_q[ix] <= '0; w_max_q[ix] <= '0;
			t_cnt_q[ix] <= '0; t_iv_q[ix] <= '0; t_sum_q[ix] <= '0; t_gap_q[ix] <= '0;
			t_min_q[ix] <= '0; t_max_q[ix] <= '0;
		end
		if (cm.err_upd && err_cnt_q[ix] != '1) err_cnt_q[ix] <= err_cnt_q[ix] + 32'd1;
		if (cm.good_upd) begin
			vote_q[ix][0] <= v0; vote_q[ix][1] <= v1; vote_q[ix][2] <= v2;
			if (role_q[ix] == ROLE_UNKNOWN && vtot >= 34'(MIN_VOTES)) begin
				if (v0 >= v1 && v0 >= v2) role_q[ix] <= ROLE_MOUSE;
				else if (v1 >= v2) role_q[ix] <= ROLE_KEYBOARD;
			end
			last_q[ix] <= ts_q;
			w_cnt_q[ix] <= (w_cnt_q[ix] == '1) ? w_cnt_q[ix] : w_cnt_q[ix] + 64'd1;
			t_cnt_q[ix] <= (t_cnt_q[ix] == '1) ? t_cnt_q[ix] : t_cnt_q[ix] + 64'd1;
			if (iv_ok) begin
				if (iv_gap) begin
					if (w_gap_q[ix] != '1) w_gap_q[ix] <= w_gap_q[ix] + 64'd1;
					if (t_gap_q[ix] != '1) t_gap_q[ix] <= t_gap_q[ix] + 64'd1;
				end else begin
					if (w_iv_q[ix] != '1) w_iv_q[ix] <= w_iv_q[ix] + 64'd1;
					if (t_iv_q[ix] != '1) t_iv_q[ix] <= t_iv_q[ix] + 64'd1;
					w_sum_q[ix] <= (w_sum_q[ix] > ~iv) ? '1 : w_sum_q[ix] + iv;
					t_sum_q[ix] <= (t_sum_q[ix] > ~iv) ? '1 : t_sum_q[ix] + iv;
					if (w_min_q[ix] == 0 || iv32 < w_min_q[ix]) w_min_q[ix] <= iv32;
					if (t_min_q[ix] == 0 || iv32 < t_min_q[ix]) t_min_q[ix] <= iv32;
					if (iv32 > w_max_q[ix]) w_max_q[ix] <= iv32;
					if (iv32 > t_max_q[ix]) t_max_q[ix] <= iv32;
				end
			end
		end
		if (cm.win_clr) begin
			w_cnt_q[ix] <= '0; w_iv_q[ix] <= '0; w_sum_q[ix] <= '0; w_gap_q[ix] <= '0;
			w_min_q[ix] <= '0; w_max_q[ix] <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cm.line_ld) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cm.line_ld) begin
			out_bus <= k_bus_q[ix]; out_device <= k_dev_q[ix]; out_endpoint <= k_ep_q[ix];
			role <= role_q[ix];
			last_item <= cm.out_last;
			if (cm.sum_sel) begin
				report_count <= t_cnt_q[ix]; interval_count <= t_iv_q[ix];
				interval_sum_ns <= t_sum_q[ix]; min_interval_ns <= t_min_q[ix];
				max_interval_ns <= t_max_q[ix]; gap_count <= t_gap_q[ix];
				error_count <= err_cnt_q[ix];
			end else begin
				report_count <= w_cnt_q[ix]; interval_count <= w_iv_q[ix];
				interval_sum_ns <= w_sum_q[ix]; min_interval_ns <= w_min_q[ix];
				max_interval_ns <= w_max_q[ix]; gap_count <= w_gap_q[ix];
				error_count <= '0;
			end
		end
	end
endmodule

@@ tb/hrrm_testbench.sv @@
// self-checking testbench of the hid report rate meter
// predicts window, stop and summary lines in step with accepted items
// depends on hrrm_pkg and hid_report_rate_meter
`timescale 1ns / 1ps

module testbench;
	import hrrm_pkg::*;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] bus;
		logic [6:0]  dev;
		logic [7:0]  ep;
		logic        dir;
		logic        err;
		logic [15:0] len;
		logic [63:0] ts;
	} xfer_t;

	typedef struct packed {
		logic [15:0] bus;
		logic [6:0]  dev;
		logic [7:0]  ep;
		logic [1:0]  role;
		logic [63:0] reports;
		logic [63:0] iv_cnt;
		logic [63:0] iv_sum;
		logic [31:0] iv_min;
		logic [31:0] iv_max;
		logic [63:0] gaps;
		logic [31:0] errs;
		logic        last;
	} line_t;

	typedef struct packed {
		logic [63:0] reports;
		logic [63:0] iv_cnt;
		logic [63:0] iv_sum;
		logic [63:0] iv_min;
		logic [63:0] iv_max;
		logic [63:0] gaps;
	} stats_t;

	localparam int SLOTS = 16;
	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = REG_ENABLE;
	logic [31:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] cmd = CMD_EVENT;
	logic [15:0] bus = '0;
	logic [6:0] device_address = '0;
	logic [7:0] endpoint = '0;
	logic dir_in = 0;
	logic status_error = 0;
	logic [15:0] report_length = '0;
	logic [63:0] timestamp_ns = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [15:0] out_bus;
	logic [6:0]  out_device;
	logic [7:0]  out_endpoint;
	logic [1:0]  role;
	logic [63:0] report_count;
	logic [63:0] interval_count;
	logic [63:0] interval_sum_ns;
	logic [31:0] min_interval_ns;
	logic [31:0] max_interval_ns;
	logic [63:0] gap_count;
	logic [31:0] error_count;
	logic        last_item;
	line_t got;

	hid_report_rate_meter i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .bus(bus), .device_address(device_address), .endpoint(endpoint),
		.dir_in(dir_in), .status_error(status_error), .report_length(report_length),
		.timestamp_ns(timestamp_ns),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_bus(out_bus), .out_device(out_device), .out_endpoint(out_endpoint),
		.role(role), .report_count(report_count), .interval_count(interval_count),
		.interval_sum_ns(interval_sum_ns), .min_interval_ns(min_interval_ns),
		.max_interval_ns(max_interval_ns), .gap_count(gap_count),
		.error_count(error_count), .last_item(last_item)
	);

	// result fields gathered into one line
	assign got = {out_bus, out_device, out_endpoint, role, report_count, interval_count,
		interval_sum_ns, min_interval_ns, max_interval_ns, gap_count, error_count,
		last_item};

	always #4 clk = ~clk;

	// meter state as the block should hold it
	logic        m_enable;
	logic [11:0] m_window_s;
	logic [31:0] m_gap_thr;
	int          m_slots;
	logic [63:0] m_win_start;
	logic [15:0] m_bus [SLOTS];
	logic [6:0]  m_dev [SLOTS];
	logic [7:0]  m_ep [SLOTS];
	logic [1:0]  m_role [SLOTS];
	logic [63:0] m_last_ts [SLOTS];
	stats_t      m_win [SLOTS];
	stats_t      m_tot [SLOTS];
	logic [31:0] m_errs [SLOTS];
	logic [31:0] m_votes [SLOTS][3];

	xfer_t pending_q[$];
	line_t lines_q[$];
	int send_idle = 0, recv_idle = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	logic [63:0] now_ns = 64'd1000;
	logic [15:0] key_bus [8];
	logic [6:0]  key_dev [8];
	logic [7:0]  key_ep [8];

	function automatic logic [63:0] sat_inc64(logic [63:0] v);
		return (&v) ? v : v + 1;
	endfunction

	function automatic logic [31:0] sat_inc32(logic [31:0] v);
		return (&v) ? v : v + 1;
	endfunction

	function automatic stats_t add_interval(stats_t st, logic [63:0] iv);
		logic [64:0] sum;
		if (iv > {32'd0, m_gap_thr}) begin
			st.gaps = sat_inc64(st.gaps);
			return st;
		end
		st.iv_cnt = sat_inc64(st.iv_cnt);
		sum = {1'b0, st.iv_sum} + {1'b0, iv};
		st.iv_sum = sum[64] ? '1 : sum[63:0];
		if (st.iv_min == 0 || iv < st.iv_min) st.iv_min = iv;
		if (iv > st.iv_max) st.iv_max = iv;
		return st;
	endfunction

	function automatic void push_line(int s, stats_t st, logic [31:0] errs);
		line_t l;
		l.bus = m_bus[s];
		l.dev = m_dev[s];
		l.ep = m_ep[s];
		l.role = m_role[s];
		l.reports = st.reports;
		l.iv_cnt = st.iv_cnt;
		l.iv_sum = st.iv_sum;
		l.iv_min = st.iv_min[31:0];
		l.iv_max = st.iv_max[31:0];
		l.gaps = st.gaps;
		l.errs = errs;
		l.last = 0;
		lines_q.push_back(l);
	endfunction

	function automatic int flush_lines(logic [63:0] at);
		int n = 0;
		for (int i = 0; i < m_slots; i++) begin
			if (m_win[i].reports != 0 && n < MAX_LINES) begin
				push_line(i, m_win[i], 32'd0);
				n++;
			end
			m_win[i] = '0;
		end
		m_win_start = at;
		return n;
	endfunction

	function automatic void vote_role(int s, logic [15:0] len);
		logic [33:0] total;
		if (len == 4) m_votes[s][0] = sat_inc32(m_votes[s][0]);
		else if (len == 8 || len == 9 || len == 17) m_votes[s][1] = sat_inc32(m_votes[s][1]);
		else m_votes[s][2] = sat_inc32(m_votes[s][2]);
		if (m_role[s] != ROLE_UNKNOWN) return;
		total = {2'b0, m_votes[s][0]} + {2'b0, m_votes[s][1]} + {2'b0, m_votes[s][2]};
		if (total < MIN_VOTES) return;
		if (m_votes[s][0] >= m_votes[s][1] && m_votes[s][0] >= m_votes[s][2])
			m_role[s] = ROLE_MOUSE;
		else if (m_votes[s][1] >= m_votes[s][2])
			m_role[s] = ROLE_KEYBOARD;
	endfunction

	function automatic int meter_transfer(xfer_t x);
		int s;
		logic [63:0] iv;
		if (!x.dir) return 0;
		for (s = 0; s < m_slots; s++)
			if (m_bus[s] == x.bus && m_dev[s] == x.dev && m_ep[s] == x.ep) break;
		if (s == m_slots) begin
			if (m_slots >= SLOTS) return 0;
			m_bus[s] = x.bus;
			m_dev[s] = x.dev;
			m_ep[s] = x.ep;
			m_role[s] = ROLE_UNKNOWN;
			m_last_ts[s] = 0;
			m_win[s] = '0;
			m_tot[s] = '0;
			m_errs[s] = 0;
			m_votes[s] = '{0, 0, 0};
			m_slots++;
		end
		if (x.err) begin
			m_errs[s] = sat_inc32(m_errs[s]);
			return 0;
		end
		vote_role(s, x.len);
		if (m_last_ts[s] != 0 && x.ts > m_last_ts[s]) begin
			iv = x.ts - m_last_ts[s];
			m_win[s] = add_interval(m_win[s], iv);
			m_tot[s] = add_interval(m_tot[s], iv);
		end
		m_last_ts[s] = x.ts;
		m_win[s].reports = sat_inc64(m_win[s].reports);
		m_tot[s].reports = sat_inc64(m_tot[s].reports);
		if (m_win_start == 0) m_win_start = x.ts;
		if (m_win_start != 0 && x.ts > m_win_start
				&& x.ts - m_win_start >= m_window_s * NS_PER_SEC)
			return flush_lines(x.ts);
		return 0;
	endfunction

	function automatic int meter_stop();
		logic [63:0] latest = 0;
		if (m_win_start == 0) return 0;
		for (int i = 0; i < m_slots; i++)
			if (m_last_ts[i] > latest) latest = m_last_ts[i];
		if (latest <= m_win_start) return 0;
		if (latest - m_win_start < m_window_s * QUARTER_SEC_NS) return 0;
		return flush_lines(latest);
	endfunction

	// work out the lines one accepted item causes
	function automatic void predict_lines(xfer_t x);
		int n = 0;
		if (!m_enable) return;
		case (x.cmd)
			CMD_EVENT: n = meter_transfer(x);
			CMD_STOP: n = meter_stop();
			CMD_SUMMARY: begin
				for (int i = 0; i < m_slots && n < MAX_LINES; i++) begin
					push_line(i, m_tot[i], m_errs[i]);
					n++;
				end
			end
			default: n = 0;
		endcase
		if (n > 0) lines_q[lines_q.size() - 1].last = 1;
	endfunction

	function automatic xfer_t mk(logic [1:0] c, int k, logic [15:0] len, logic [63:0] ts);
		xfer_t x;
		x.cmd = c;
		x.bus = key_bus[k];
		x.dev = key_dev[k];
		x.ep = key_ep[k];
		x.dir = 1;
		x.err = 0;
		x.len = len;
		x.ts = ts;
		return x;
	endfunction

	// one random item: mostly good transfers on a few keys, some noise
	function automatic xfer_t rand_xfer();
		xfer_t x;
		int r = $urandom_range(99);
		int p = $urandom_range(99);
		logic [63:0] win_ns = m_window_s * NS_PER_SEC;
		x = mk(CMD_EVENT, $urandom_range(4), 16'd4, 0);
		if (r < 7) x.cmd = CMD_STOP;
		else if (r < 14) x.cmd = CMD_SUMMARY;
		else if (r < 17) x.cmd = 2'd3;
		if (p < 20) begin
			x.bus = 16'($urandom);
			x.dev = 7'($urandom);
			x.ep = 8'($urandom);
		end
		r = $urandom_range(99);
		if (r < 40) x.len = 16'd4;
		else if (r < 50) x.len = 16'd8;
		else if (r < 57) x.len = 16'd9;
		else if (r < 64) x.len = 16'd17;
		else x.len = 16'($urandom);
		x.dir = $urandom_range(99) >= 6;
		x.err = $urandom_range(99) < 8;
		r = $urandom_range(99);
		if (r < 65) now_ns += $urandom_range(20000000, 100000);
		else if (r < 80) now_ns += {32'd0, m_gap_thr} + $urandom_range(1000000);
		else if (r < 92) now_ns += win_ns / 4 + win_ns * $urandom_range(9) / 8;
		x.ts = ($urandom_range(99) < 3) ? 64'd0 : now_ns;
		return x;
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		xfer_t x;
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_lines({cmd, bus, device_address, endpoint, dir_in, status_error,
					report_length, timestamp_ns});
			if (!in_valid || !in_stall) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					x = pending_q.pop_front();
					{cmd, bus, device_address, endpoint, dir_in, status_error,
						report_length, timestamp_ns} <= x;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		line_t want;
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (lines_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected line %p", got);
				end else begin
					want = lines_q.pop_front();
					if (want !== got) begin
						mismatches++;
						if (mismatches <= 10)
							$display("line mismatch\n  expected %p\n  actual   %p", want, got);
					end
				end
			end
			out_stall <= $urandom_range(99) < recv_idle;
		end
	end

	// watchdog on cycles with no accepted item on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL hid_report_rate_meter");
			$finish;
		end
	end

	task automatic wait_idle();
		wait (pending_q.size() == 0 && !in_valid && lines_q.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_ENABLE: m_enable = val[0];
			REG_WINDOW: m_window_s = val[11:0];
			default: m_gap_thr = val;
		endcase
	endtask

	task automatic run_random(int n);
		repeat (n) pending_q.push_back(rand_xfer());
	endtask

	initial begin
		xfer_t x;
		m_enable = 1;
		m_window_s = 1;
		m_gap_thr = GAP_RESET;
		m_slots = 0;
		m_win_start = 0;
		for (int k = 0; k < 8; k++) begin
			key_bus[k] = 16'($urandom);
			key_dev[k] = 7'($urandom);
			key_ep[k] = 8'($urandom);
		end
		key_bus[1] = 16'hFFFF;
		key_dev[1] = 7'h7F;
		key_ep[1] = 8'hFF;
		key_bus[2] = 0;
		key_dev[2] = 0;
		key_ep[2] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, role votes, errors, ignored items, gap, flush, stop
		pending_q.push_back(mk(CMD_SUMMARY, 0, 0, 0));
		pending_q.push_back(mk(CMD_STOP, 0, 0, 0));
		pending_q.push_back(mk(CMD_EVENT, 1, 16'd0, 64'd0));
		for (int i = 0; i < 8; i++)
			pending_q.push_back(mk(CMD_EVENT, 0, 16'd4, 64'd1000 + i * 64'd8000000));
		pending_q.push_back(mk(CMD_EVENT, 1, 16'hFFFF, 64'd70000000));
		pending_q.push_back(mk(CMD_EVENT, 1, 16'd8, 64'd71000000));
		pending_q.push_back(mk(CMD_EVENT, 1, 16'd9, 64'd200000000));
		x = mk(CMD_EVENT, 0, 16'd17, 64'd210000000);
		x.err = 1;
		pending_q.push_back(x);
		x = mk(CMD_EVENT, 2, 16'd4, 64'd211000000);
		x.dir = 0;
		pending_q.push_back(x);
		pending_q.push_back(mk(2'd3, 2, 16'd8, 64'd212000000));
		pending_q.push_back(mk(CMD_EVENT, 2, 16'd17, 64'd212000000));
		pending_q.push_back(mk(CMD_EVENT, 2, 16'd8, 64'd1100000000));
		pending_q.push_back(mk(CMD_EVENT, 0, 16'd4, 64'd1200000000));
		pending_q.push_back(mk(CMD_STOP, 0, 0, 0));
		pending_q.push_back(mk(CMD_EVENT, 1, 16'd4, 64'd1400000000));
		pending_q.push_back(mk(CMD_STOP, 0, 0, 0));
		pending_q.push_back(mk(CMD_SUMMARY, 0, 0, 0));
		now_ns = 64'd1500000000;
		wait_idle();

		// window zero, widest gap threshold, receiver mostly stalled
		write_reg(REG_WINDOW, 32'd0);
		write_reg(REG_GAP, 32'hFFFFFFFF);
		send_idle = 17;
		recv_idle = 56;
		run_random(35);
		wait_idle();

		// longest window, every interval a gap, sender mostly idle
		write_reg(REG_WINDOW, 32'd4095);
		write_reg(REG_GAP, 32'd1);
		send_idle = 56;
		recv_idle = 17;
		run_random(30);
		pending_q.push_back(mk(CMD_STOP, 0, 0, 0));
		wait_idle();

		// meter off: nothing comes out
		write_reg(REG_ENABLE, 32'd0);
		run_random(8);
		pending_q.push_back(mk(CMD_SUMMARY, 0, 0, 0));
		wait_idle();

		// defaults back, no idling, then the latest possible timestamp
		write_reg(REG_ENABLE, 32'd1);
		write_reg(REG_WINDOW, 32'd1);
		write_reg(REG_GAP, GAP_RESET);
		send_idle = 0;
		recv_idle = 0;
		run_random(30);
		pending_q.push_back(mk(CMD_EVENT, 0, 16'd4, 64'hFFFFFFFFFFFFFFFF));
		pending_q.push_back(mk(CMD_STOP, 0, 0, 0));
		pending_q.push_back(mk(CMD_SUMMARY, 0, 0, 0));
		wait (pending_q.size() == 0 && !in_valid && lines_q.size() == 0);
		repeat (200) @(posedge clk);

		mismatches += lines_q.size();
		if (mismatches == 0)
			$display("PASS hid_report_rate_meter");
		else
			$display("FAIL hid_report_rate_meter");
		$finish;
	end

endmodule
